// ===== rtl/arice_pkg.sv =====
// Shared types, constants and helper functions of the adaptive Rice decoder.
package arice_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int QUOT_WIDTH  = 16;
  localparam int K_MAX       = 15;
  localparam int K_WIDTH     = 4;
  localparam int BYTE_WIDTH  = 8;
  localparam int LEN_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int POS_WIDTH   = $clog2(BYTE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0]  val_t;
  typedef logic [QUOT_WIDTH-1:0]   quot_t;
  typedef logic [QUOT_WIDTH:0]     ext1_t;
  typedef logic [QUOT_WIDTH+1:0]   ext2_t;
  typedef logic [QUOT_WIDTH+4:0]   dclen_t;
  typedef logic [K_WIDTH-1:0]      k_t;
  typedef logic [K_WIDTH:0]        kx_t;
  typedef logic [LEN_WIDTH-1:0]    len_t;
  typedef logic [POS_WIDTH-1:0]    bitpos_t;
  typedef logic [BYTE_WIDTH-1:0]   byte_t;

  localparam quot_t   QUOT_MAX = '1;
  localparam bitpos_t BIT_LAST = bitpos_t'(BYTE_WIDTH - 1);

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_DC,
    MODE_LL,
    MODE_EXP
  } mode_t;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_SIGNED_MAP = 2'd1;
  localparam logic [1:0] REG_ADAPT      = 2'd2;
  localparam logic [1:0] REG_START_K    = 2'd3;

  typedef struct packed {
    mode_t mode;
    logic  signed_map;
    logic  adapt_enable;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic data;
    logic last;
  } bit_t;

  typedef struct packed {
    val_t value;
    k_t   k_after;
    logic overflow;
  } res_t;

  // Adaptation of k after a plain symbol with quotient q.
  function automatic k_t adapt_k(quot_t q, k_t k);
    kx_t lg;
    kx_t sum;
    lg = '0;
    for (int i = 1; i < QUOT_WIDTH; i++) begin
      if (q[i]) begin
        lg = kx_t'(i);
      end
    end
    sum = kx_t'(k) + lg;
    if (q == '0) begin
      adapt_k = (k == '0) ? '0 : k - k_t'(1);
    end else if (q == quot_t'(1)) begin
      adapt_k = k;
    end else if (sum > kx_t'(K_MAX)) begin
      adapt_k = k_t'(K_MAX);
    end else begin
      adapt_k = k_t'(sum);
    end
  endfunction

  // Zigzag mapping from an unsigned code to two's complement bits.
  function automatic val_t zigzag(val_t v);
    zigzag = (v >> 1) ^ {VALUE_WIDTH{v[0]}};
  endfunction

endpackage

// ===== rtl/arice_bit_shifter.sv =====
// Input byte register that hands out one stream bit per cycle while adv is high, most significant first.
module arice_bit_shifter (
  input  logic             clk,
  input  logic             rst,
  input  logic             stream_valid,
  output logic             stream_ready,
  input  arice_pkg::byte_t stream_byte,
  input  logic             adv,
  output arice_pkg::bit_t  bit_out
);
  import arice_pkg::*;

  byte_t   shreg;
  bitpos_t pos;
  logic    busy;

  assign bit_out.valid = busy;
  assign bit_out.data  = shreg[BYTE_WIDTH-1];
  assign bit_out.last  = (pos == BIT_LAST);

  assign stream_ready = !busy || (adv && bit_out.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (stream_valid && stream_ready) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (adv) begin
      pos <= pos + bitpos_t'(1);
      if (bit_out.last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream_valid && stream_ready) begin
      shreg <= stream_byte;
    end else if (adv) begin
      shreg <= {shreg[BYTE_WIDTH-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/arice_symbol_engine.sv =====
// Bit-serial Rice symbol decoder with escape modes and adaptation of k.
module arice_symbol_engine (
  input  logic            clk,
  input  logic            rst,
  input  arice_pkg::cfg_t cfg,
  input  logic            restart,
  input  arice_pkg::k_t   restart_k,
  input  arice_pkg::bit_t bit_in,
  input  logic            slot_ok,
  output logic            adv,
  output logic            push,
  output arice_pkg::res_t res
);
  import arice_pkg::*;

  typedef enum logic [1:0] {
    PH_UNARY,
    PH_REM,
    PH_ESC,
    PH_MANT
  } phase_t;

  phase_t phase, phase_next;
  quot_t  quot, quot_next;
  len_t   bits_left, bits_left_next;
  val_t   accum, accum_next;
  k_t     cur_k, cur_k_next;
  logic   err, err_next;

  logic   emit_now;
  logic   do_adapt;
  logic   do_finish;
  val_t   shifted;
  val_t   fin_val;
  val_t   exp_len;
  len_t   bits_dec;
  quot_t  esc;
  quot_t  ll_i;
  kx_t    kp5;
  dclen_t dc_len;
  ext2_t  dc_k;
  ext2_t  ll_len;
  ext2_t  ll_k;

  always_comb begin
    phase_next     = phase;
    quot_next      = quot;
    bits_left_next = bits_left;
    accum_next     = accum;
    cur_k_next     = cur_k;
    err_next       = err;
    emit_now       = 1'b0;
    do_adapt       = 1'b0;
    do_finish      = 1'b0;
    res            = '0;

    esc      = quot - quot_t'(7) - quot_t'(cur_k);
    kp5      = kx_t'(cur_k) + kx_t'(5);
    dc_len   = dclen_t'(esc) * dclen_t'(kp5);
    dc_k     = ext2_t'(cur_k) + (ext2_t'(esc) << 1);
    ll_i     = quot - quot_t'(8);
    ll_len   = (ext2_t'(ll_i) << 1) + ext2_t'(ll_i) + ext2_t'(5);
    ll_k     = ext2_t'(cur_k) + ext2_t'(ll_i) + ext2_t'(3);
    shifted  = {accum[VALUE_WIDTH-2:0], bit_in.data};
    bits_dec = (bits_left != '0) ? bits_left - len_t'(1) : '0;
    fin_val  = shifted;
    exp_len  = '0;

    case (phase)
      PH_UNARY: begin
        if (bit_in.data) begin
          if (quot == QUOT_MAX) begin
            err_next = 1'b1;
          end else begin
            quot_next = quot + quot_t'(1);
          end
        end else if (cfg.mode == MODE_DC && ext1_t'(quot) >= ext1_t'(8) + ext1_t'(cur_k)) begin
          if (dc_len > dclen_t'(VALUE_WIDTH)) begin
            err_next       = 1'b1;
            bits_left_next = len_t'(VALUE_WIDTH);
          end else begin
            bits_left_next = len_t'(dc_len);
          end
          if (cfg.adapt_enable) begin
            cur_k_next = (dc_k > ext2_t'(K_MAX)) ? k_t'(K_MAX) : k_t'(dc_k);
          end
          accum_next = '0;
          phase_next = PH_ESC;
        end else if ((cfg.mode == MODE_LL || cfg.mode == MODE_EXP) && quot >= quot_t'(8)) begin
          if (ll_len > ext2_t'(VALUE_WIDTH)) begin
            err_next       = 1'b1;
            bits_left_next = len_t'(VALUE_WIDTH);
          end else begin
            bits_left_next = len_t'(ll_len);
          end
          if (cfg.adapt_enable) begin
            cur_k_next = (ll_k > ext2_t'(K_MAX)) ? k_t'(K_MAX) : k_t'(ll_k);
          end
          accum_next = '0;
          phase_next = PH_ESC;
        end else begin
          accum_next     = val_t'(quot);
          fin_val        = val_t'(quot);
          bits_left_next = len_t'(cur_k);
          phase_next     = PH_REM;
          if (cur_k == '0) begin
            do_adapt  = 1'b1;
            do_finish = 1'b1;
          end
        end
      end
      default: begin
        if (accum[VALUE_WIDTH-1]) begin
          err_next = 1'b1;
        end
        accum_next     = shifted;
        bits_left_next = bits_dec;
        if (bits_dec == '0) begin
          if (phase == PH_REM) begin
            do_adapt  = 1'b1;
            do_finish = 1'b1;
          end else if (phase == PH_ESC) begin
            do_finish = 1'b1;
          end else begin
            emit_now = 1'b1;
          end
        end
      end
    endcase

    if (do_adapt && cfg.adapt_enable) begin
      cur_k_next = adapt_k(quot, cur_k);
    end

    if (do_finish) begin
      if (cfg.mode != MODE_EXP) begin
        emit_now = 1'b1;
      end else begin
        exp_len    = fin_val >> 4;
        accum_next = val_t'(fin_val[3:0]);
        if (exp_len > val_t'(VALUE_WIDTH)) begin
          err_next       = 1'b1;
          bits_left_next = len_t'(VALUE_WIDTH);
        end else begin
          bits_left_next = len_t'(exp_len);
        end
        if (bits_left_next == '0) begin
          emit_now = 1'b1;
        end else begin
          phase_next = PH_MANT;
        end
      end
    end

    if (emit_now) begin
      res.value    = (cfg.signed_map && (cfg.mode == MODE_PLAIN || cfg.mode == MODE_DC))
                     ? zigzag(accum_next) : accum_next;
      res.k_after  = cur_k_next;
      res.overflow = err_next;
      phase_next     = PH_UNARY;
      quot_next      = '0;
      bits_left_next = '0;
      accum_next     = '0;
      err_next       = 1'b0;
    end
  end

  assign adv  = bit_in.valid && (!emit_now || slot_ok);
  assign push = adv && emit_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_UNARY;
      quot      <= '0;
      bits_left <= '0;
      accum     <= '0;
      cur_k     <= '0;
      err       <= 1'b0;
    end else if (restart) begin
      phase     <= PH_UNARY;
      quot      <= '0;
      bits_left <= '0;
      accum     <= '0;
      cur_k     <= restart_k;
      err       <= 1'b0;
    end else if (adv) begin
      phase     <= phase_next;
      quot      <= quot_next;
      bits_left <= bits_left_next;
      accum     <= accum_next;
      cur_k     <= cur_k_next;
      err       <= err_next;
    end
  end

endmodule

// ===== rtl/arice_result_buffer.sv =====
// Hold slot and output register that mark the last result of each byte.
module arice_result_buffer (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  arice_pkg::res_t res,
  input  logic            end_byte,
  output logic            slot_ok,
  output logic            result_valid,
  input  logic            result_ready,
  output arice_pkg::res_t out_res,
  output logic            last_of_byte
);
  import arice_pkg::*;

  res_t hold_res;
  logic hold_v;
  logic hold_last;
  logic out_free;
  logic hold_move;

  assign out_free  = !result_valid || result_ready;
  assign hold_move = hold_v && out_free && (hold_last || push);
  assign slot_ok   = !hold_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      last_of_byte <= 1'b0;
      hold_v       <= 1'b0;
      hold_last    <= 1'b0;
    end else begin
      if (hold_move) begin
        result_valid <= 1'b1;
        last_of_byte <= hold_last;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
      if (push) begin
        hold_v    <= 1'b1;
        hold_last <= end_byte;
      end else if (hold_move) begin
        hold_v    <= 1'b0;
        hold_last <= 1'b0;
      end else if (end_byte && hold_v) begin
        hold_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move) begin
      out_res <= hold_res;
    end
    if (push) begin
      hold_res <= res;
    end
  end

endmodule

// ===== rtl/adaptive_rice_decoder_top.sv =====
// Top level of the adaptive Rice decoder: configuration registers and datapath wiring.
// Each input byte goes one stream bit per cycle through the symbol engine, unless the engine stalls.
// The next byte is accepted in the cycle of the previous byte's last bit.
// The last result of a byte is registered in the hold slot and then in the output register.
// Output backpressure stalls the engine only when a finished symbol finds both slots full.
// Reset is synchronous: configuration returns to its defaults, k to zero, buffers empty.
module adaptive_rice_decoder_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             stream_valid,
  output logic             stream_ready,
  input  arice_pkg::byte_t stream_byte,
  output logic             result_valid,
  input  logic             result_ready,
  output arice_pkg::val_t  value,
  output arice_pkg::k_t    k_after,
  output logic             overflow,
  output logic             last_of_byte,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data
);
  import arice_pkg::*;

  cfg_t cfg;
  bit_t bit_s;
  res_t eng_res;
  res_t out_res;
  logic adv;
  logic push;
  logic slot_ok;
  logic restart;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_index == REG_START_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_PLAIN;
      cfg.signed_map   <= 1'b0;
      cfg.adapt_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:       cfg.mode         <= mode_t'(cfg_data[1:0]);
        REG_SIGNED_MAP: cfg.signed_map   <= cfg_data[0];
        REG_ADAPT:      cfg.adapt_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  arice_bit_shifter u_shifter (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_byte  (stream_byte),
    .adv          (adv),
    .bit_out      (bit_s)
  );

  arice_symbol_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .restart_k (cfg_data),
    .bit_in    (bit_s),
    .slot_ok   (slot_ok),
    .adv       (adv),
    .push      (push),
    .res       (eng_res)
  );

  arice_result_buffer u_buffer (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res          (eng_res),
    .end_byte     (adv && bit_s.last),
    .slot_ok      (slot_ok),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_res      (out_res),
    .last_of_byte (last_of_byte)
  );

  assign value    = out_res.value;
  assign k_after  = out_res.k_after;
  assign overflow = out_res.overflow;

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (stream_valid && stream_ready) |=> bit_s.valid)
    else $error("accepted byte did not reach the bit shifter");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (bit_s.valid && !adv) |-> !slot_ok)
    else $error("engine stalled while a result slot was free");

  a_byte_drains: assert property (@(posedge clk) disable iff (rst)
    (adv && bit_s.last && !(stream_valid && stream_ready)) |=> !bit_s.valid)
    else $error("bit shifter still busy after the last bit of a byte");
`endif

endmodule
